// ===== rtl/htv_pkg.sv =====
// ----------------------------------------------------------------------------
// htv_pkg
// shared types, constants and the arctangent table of the helix tube vertex
// ----------------------------------------------------------------------------
`default_nettype none

package htv_pkg;

  // cordic datapath widths
  localparam int XY_W = 32;
  localparam int Z_W  = 32;
  localparam int ATAN_COUNT = 24;

  // scaled height term w*h, signed
  localparam int WH_W = 35;

  // slope factors, unsigned q.30 up to one
  localparam int K_W = 31;

  localparam logic signed [XY_W-1:0] GAIN_Q30   = 32'sd652032875;
  localparam logic        [31:0]     TWO_PI_Q29 = 32'd3373259426;
  localparam logic        [K_W-1:0]  ONE_Q30    = 31'h4000_0000;

  // output limits
  localparam logic signed [22:0] POS_HI = 23'h3F_FFFF;
  localparam logic signed [22:0] POS_LO = 23'h40_0000;
  localparam logic signed [15:0] NRM_HI = 16'sh4000;
  localparam logic signed [15:0] NRM_LO = 16'shC000;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef enum logic [1:0] {REG_RADIUS, REG_HEIGHT, REG_FIBER, REG_LOOPS} reg_idx_t;

  typedef enum logic [2:0] {
    SL_RL, SL_SCALE, SL_NORM, SL_SQUARE, SL_ROOT, SL_DIV, SL_DONE
  } slope_state_t;

  typedef struct packed {
    logic signed [XY_W-1:0] sin_v;
    logic signed [XY_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic [K_W-1:0] kn;
    logic [K_W-1:0] ks;
  } slope_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [Z_W-1:0] atan_turn(input int idx);
    logic [Z_W-1:0] t;
    case (idx)
      0:  t = 32'd536870912;
      1:  t = 32'd316933406;
      2:  t = 32'd167458907;
      3:  t = 32'd85004756;
      4:  t = 32'd42667331;
      5:  t = 32'd21354465;
      6:  t = 32'd10679838;
      7:  t = 32'd5340245;
      8:  t = 32'd2670163;
      9:  t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/helix_tube_vertex.sv =====
// ----------------------------------------------------------------------------
// helix_tube_vertex
// one vertex position and unit normal of a tube swept along a helix per (u,v)
// ----------------------------------------------------------------------------
//
//   channel   signals                                  transfer when
//   -------   --------------------------------------   ----------------------
//   input     in_valid/in_ready, around/along_fraction  in_valid && in_ready
//   output    out_valid/out_ready, position_*, normal_*, out_valid && out_ready
//             saturated
//   config    apb psel/penable/pwrite/paddr/pwdata      psel && penable && pwrite
//
// one transfer per cycle in each direction while nothing stalls; the pipe has
// two phase multiply stages, the cordic rotations plus a quadrant stage, four
// surface stages. every stage has its own valid bit and moves when the next
// one has room, so bubbles close up under output stall and nothing is dropped.
// after reset, and after a write to center_radius or turns_per_unit, the slope
// unit (shift normalize, bit-serial square root, two radix-2 dividers) runs
// with in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module helix_tube_vertex #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [16:0]        around_fraction,
  input  logic [16:0]        along_fraction,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [22:0] position_x,
  output logic signed [22:0] position_y,
  output logic signed [22:0] position_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               saturated
);
  import htv_pkg::*;

  // configuration registers, q8.8
  logic [15:0] center_radius;
  logic [15:0] half_height;
  logic [15:0] tube_radius;
  logic [15:0] turns_per_unit;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     slope_start;
  slope_t   coef;
  logic     coef_ok;

  // front stages: w*h, then the helix phase
  logic                   f1_v, f2_v;
  logic                   en_f1, en_f2;
  logic [15:0]            u1, u2;
  logic signed [WH_W-1:0] wh1, wh2;
  logic [31:0]            ph2;
  logic signed [18:0]     w_in;
  logic signed [WH_W-1:0] m_wh;
  logic [47:0]            m_ph;

  // cordic to surface
  logic                   cor_in_ready;
  logic                   cor_valid;
  logic                   srf_ready;
  trig_t                  trig_c, trig_a;
  logic [WH_W-1:0]        cor_side;

  // apb: the register lands on the access phase
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_idx     = reg_idx_t'(paddr[3:2]);
  // only radius and loops feed the slope factors
  assign slope_start = cfg_wr && (cfg_idx == REG_RADIUS || cfg_idx == REG_LOOPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_radius  <= 16'd256;
      half_height    <= 16'd256;
      tube_radius    <= 16'd64;
      turns_per_unit <= 16'd256;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RADIUS: center_radius  <= pwdata[15:0];
        REG_HEIGHT: half_height    <= pwdata[15:0];
        REG_FIBER:  tube_radius    <= pwdata[15:0];
        REG_LOOPS:  turns_per_unit <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RADIUS: prdata = {16'd0, center_radius};
      REG_HEIGHT: prdata = {16'd0, half_height};
      REG_FIBER:  prdata = {16'd0, tube_radius};
      REG_LOOPS:  prdata = {16'd0, turns_per_unit};
    endcase
  end

  // slope factors depend only on configuration
  htv_slope u_slope (
    .clk            (clk),
    .rst            (rst),
    .start          (slope_start),
    .center_radius  (center_radius),
    .turns_per_unit (turns_per_unit),
    .coef           (coef),
    .coef_ok        (coef_ok)
  );

  // stall chain for the two front stages
  assign en_f2    = !f2_v || cor_in_ready;
  assign en_f1    = !f1_v || en_f2;
  assign in_ready = en_f1 && coef_ok;

  // w = 2v - 1 in q.16, up to about 3 for v above one
  assign w_in = $signed({1'b0, along_fraction, 1'b0}) - 19'sd65536;
  assign m_wh = w_in * $signed({1'b0, half_height});
  // phase in turns, only the low 32 bits matter
  assign m_ph = wh1[31:0] * turns_per_unit;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else begin
      if (en_f1) f1_v <= in_valid && coef_ok;
      if (en_f2) f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f1) begin
      u1  <= around_fraction[15:0];
      wh1 <= m_wh;
    end
    if (en_f2) begin
      u2  <= u1;
      wh2 <= wh1;
      ph2 <= m_ph[31:0];
    end
  end

  htv_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (WH_W)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f2_v),
    .in_ready  (cor_in_ready),
    .phase_c   (ph2),
    .phase_a   ({u2, 16'd0}),
    .side_in   (wh2),
    .out_valid (cor_valid),
    .out_ready (srf_ready),
    .trig_c    (trig_c),
    .trig_a    (trig_a),
    .side_out  (cor_side)
  );

  htv_surface u_surface (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (cor_valid),
    .in_ready      (srf_ready),
    .trig_c        (trig_c),
    .trig_a        (trig_a),
    .wh            ($signed(cor_side)),
    .center_radius (center_radius),
    .tube_radius   (tube_radius),
    .coef          (coef),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .position_x    (position_x),
    .position_y    (position_y),
    .position_z    (position_z),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .saturated     (saturated)
  );

  // a slope recompute must close the input on the next cycle
  a_slope_blocks: assert property (@(posedge clk) disable iff (rst)
    slope_start |=> !in_ready)
    else $error("input open while slope factors recompute");

  // a saturated result has a clipped component
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (position_x == POS_HI || position_x == POS_LO ||
       position_y == POS_HI || position_y == POS_LO ||
       position_z == POS_HI || position_z == POS_LO))
    else $error("saturated flag without a clipped position");

  // normals stay within one
  a_nrm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (normal_x <= NRM_HI && normal_x >= NRM_LO &&
       normal_y <= NRM_HI && normal_y >= NRM_LO &&
       normal_z <= NRM_HI && normal_z >= NRM_LO))
    else $error("normal component out of range");

endmodule

`default_nettype wire

// ===== rtl/htv_slope.sv =====
// ----------------------------------------------------------------------------
// htv_slope
// sequential unit for the tube slope factors kn = s/n and ks = 1/n
// ----------------------------------------------------------------------------
`default_nettype none

module htv_slope (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [15:0]     center_radius,
  input  logic [15:0]     turns_per_unit,
  output htv_pkg::slope_t coef,
  output logic            coef_ok
);
  import htv_pkg::*;

  slope_state_t state, state_next;

  logic [31:0] rl;
  logic [63:0] g;
  logic [5:0]  e;
  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [31:0] m;
  logic [31:0] rem_n;
  logic [31:0] rem_s;
  logic [30:0] num_n;
  logic [30:0] quo_n;
  logic [30:0] quo_s;
  logic [4:0]  cnt;

  logic [63:0] g_sq;
  logic [63:0] g_scaled;
  logic [63:0] root_try;
  logic [32:0] t_n;
  logic [32:0] t_s;
  logic        norm_done;

  assign g_sq      = g[30:0] * g[30:0];
  assign g_scaled  = rl * TWO_PI_Q29;
  assign root_try  = res + bitv;
  assign t_n       = {rem_n, num_n[30]};
  assign t_s       = {rem_s, 1'b0};
  assign norm_done = (g[63:31] == '0) && (e <= 6'd30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SL_RL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SL_RL:     state_next = SL_SCALE;
      SL_SCALE:  state_next = SL_NORM;
      SL_NORM:   if (norm_done) state_next = SL_SQUARE;
      SL_SQUARE: state_next = SL_ROOT;
      SL_ROOT:   if (bitv == '0) state_next = SL_DIV;
      SL_DIV:    if (cnt == 5'd30) state_next = SL_DONE;
      SL_DONE:   state_next = SL_DONE;
    endcase
    if (start) begin
      state_next = SL_RL;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SL_RL: begin
        rl <= center_radius * turns_per_unit;
      end
      SL_SCALE: begin
        g <= g_scaled;
        e <= 6'd45;
      end
      SL_NORM: begin
        if (!norm_done) begin
          g <= g >> 1;
          e <= e - 6'd1;
        end
      end
      SL_SQUARE: begin
        x    <= g_sq + (64'd1 << {e, 1'b0});
        res  <= '0;
        bitv <= 64'd1 << 62;
      end
      SL_ROOT: begin
        if (bitv != '0) begin
          if (x >= root_try) begin
            x   <= x - root_try;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          m     <= (res[31:0] == '0) ? 32'd1 : res[31:0];
          rem_n <= 32'(g[30:1]);
          num_n <= {g[0], 30'd0};
          rem_s <= 32'd1 << (e - 6'd1);
          quo_n <= '0;
          quo_s <= '0;
          cnt   <= '0;
        end
      end
      SL_DIV: begin
        // one restoring quotient bit per cycle for both factors
        if (t_n >= {1'b0, m}) begin
          rem_n <= 32'(t_n - {1'b0, m});
          quo_n <= {quo_n[29:0], 1'b1};
        end else begin
          rem_n <= t_n[31:0];
          quo_n <= {quo_n[29:0], 1'b0};
        end
        if (t_s >= {1'b0, m}) begin
          rem_s <= 32'(t_s - {1'b0, m});
          quo_s <= {quo_s[29:0], 1'b1};
        end else begin
          rem_s <= t_s[31:0];
          quo_s <= {quo_s[29:0], 1'b0};
        end
        num_n <= num_n << 1;
        cnt   <= cnt + 5'd1;
      end
      SL_DONE: begin
      end
    endcase
  end

  assign coef.kn = (quo_n > ONE_Q30) ? ONE_Q30 : quo_n;
  assign coef.ks = (quo_s > ONE_Q30) ? ONE_Q30 : quo_s;
  assign coef_ok = (state == SL_DONE);

endmodule

`default_nettype wire

// ===== rtl/htv_cordic.sv =====
// ----------------------------------------------------------------------------
// htv_cordic
// pipelined sine and cosine of the helix phase and the tube angle
// ----------------------------------------------------------------------------
`default_nettype none

module htv_cordic #(
  parameter int STAGES = 16,
  parameter int SIDE_W = 35
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        phase_c,
  input  logic [31:0]        phase_a,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               out_valid,
  input  logic               out_ready,
  output htv_pkg::trig_t     trig_c,
  output htv_pkg::trig_t     trig_a,
  output logic [SIDE_W-1:0]  side_out
);
  import htv_pkg::*;

  logic              v  [STAGES+1];
  logic [STAGES:0]   en;

  logic signed [XY_W-1:0] xc [STAGES];
  logic signed [XY_W-1:0] yc [STAGES];
  logic signed [XY_W-1:0] xa [STAGES];
  logic signed [XY_W-1:0] ya [STAGES];
  logic signed [Z_W-1:0]  zc [STAGES];
  logic signed [Z_W-1:0]  za [STAGES];
  quad_t                  qc [STAGES];
  quad_t                  qa [STAGES];
  logic [SIDE_W-1:0]      sd [STAGES];

  function automatic trig_t quad_map(input quad_t q, input logic signed [XY_W-1:0] cx,
                                     input logic signed [XY_W-1:0] cy);
    trig_t r;
    case (q)
      QUAD_0: begin r.sin_v = cy;  r.cos_v = cx;  end
      QUAD_1: begin r.sin_v = cx;  r.cos_v = -cy; end
      QUAD_2: begin r.sin_v = -cy; r.cos_v = -cx; end
      QUAD_3: begin r.sin_v = -cx; r.cos_v = cy;  end
      default: begin r.sin_v = cy; r.cos_v = cx; end
    endcase
    return r;
  endfunction

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[STAGES] = !v[STAGES] || out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  for (genvar j = 0; j < STAGES; j++) begin : g_rot
    logic                   sv;
    logic signed [XY_W-1:0] sxc, syc, sxa, sya;
    logic signed [Z_W-1:0]  szc, sza;
    quad_t                  sqc, sqa;
    logic [SIDE_W-1:0]      ssd;

    if (j == 0) begin : g_src
      assign sv  = in_valid;
      assign sxc = GAIN_Q30;
      assign syc = '0;
      assign sxa = GAIN_Q30;
      assign sya = '0;
      assign szc = {2'b00, phase_c[29:0]};
      assign sza = {2'b00, phase_a[29:0]};
      assign sqc = quad_t'(phase_c[31:30]);
      assign sqa = quad_t'(phase_a[31:30]);
      assign ssd = side_in;
    end else begin : g_src
      assign sv  = v[j-1];
      assign sxc = xc[j-1];
      assign syc = yc[j-1];
      assign sxa = xa[j-1];
      assign sya = ya[j-1];
      assign szc = zc[j-1];
      assign sza = za[j-1];
      assign sqc = qc[j-1];
      assign sqa = qa[j-1];
      assign ssd = sd[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        if (!szc[Z_W-1]) begin
          xc[j] <= sxc - (syc >>> j);
          yc[j] <= syc + (sxc >>> j);
          zc[j] <= szc - $signed(atan_turn(j));
        end else begin
          xc[j] <= sxc + (syc >>> j);
          yc[j] <= syc - (sxc >>> j);
          zc[j] <= szc + $signed(atan_turn(j));
        end
        if (!sza[Z_W-1]) begin
          xa[j] <= sxa - (sya >>> j);
          ya[j] <= sya + (sxa >>> j);
          za[j] <= sza - $signed(atan_turn(j));
        end else begin
          xa[j] <= sxa + (sya >>> j);
          ya[j] <= sya - (sxa >>> j);
          za[j] <= sza + $signed(atan_turn(j));
        end
        qc[j] <= sqc;
        qa[j] <= sqa;
        sd[j] <= ssd;
      end
    end
  end

  // quadrant fold-out stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[STAGES] <= 1'b0;
    end else if (en[STAGES]) begin
      v[STAGES] <= v[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES]) begin
      trig_c   <= quad_map(qc[STAGES-1], xc[STAGES-1], yc[STAGES-1]);
      trig_a   <= quad_map(qa[STAGES-1], xa[STAGES-1], ya[STAGES-1]);
      side_out <= sd[STAGES-1];
    end
  end

  assign out_valid = v[STAGES];

endmodule

`default_nettype wire

// ===== rtl/htv_surface.sv =====
// ----------------------------------------------------------------------------
// htv_surface
// tube offset, position sums with saturation and unit normal, four stages
// ----------------------------------------------------------------------------
`default_nettype none

module htv_surface (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  htv_pkg::trig_t                   trig_c,
  input  htv_pkg::trig_t                   trig_a,
  input  logic signed [htv_pkg::WH_W-1:0]  wh,
  input  logic [15:0]                      center_radius,
  input  logic [15:0]                      tube_radius,
  input  htv_pkg::slope_t                  coef,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [22:0]               position_x,
  output logic signed [22:0]               position_y,
  output logic signed [22:0]               position_z,
  output logic signed [15:0]               normal_x,
  output logic signed [15:0]               normal_y,
  output logic signed [15:0]               normal_z,
  output logic                             saturated
);
  import htv_pkg::*;

  localparam int XU_W = XY_W + 1;
  localparam int S_W  = 52;
  localparam logic signed [S_W-1:0] ROUND_HALF = 52'sd33554432;
  localparam logic signed [XU_W:0]  NRM_HALF   = 34'sd32768;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // stage 1
  logic signed [XY_W-1:0] casc1, cacc1, sak1, sakn1, sc1, cc1;
  logic signed [WH_W-1:0] wh1;
  // stage 2
  logic signed [XU_W-1:0] ux2, uy2, uz2;
  logic signed [XY_W-1:0] sc2, cc2;
  logic signed [WH_W-1:0] wh2;
  // stage 3
  logic signed [S_W-1:0]  rx3, ry3, rz3, cx3, cy3, cz3;
  logic signed [15:0]     nx3, ny3, nz3;

  logic signed [63:0] m_casc, m_cacc, m_sak, m_sakn, m_sakc, m_saks;
  logic signed [S_W-1:0] m_rx, m_ry, m_rz, m_cx, m_cy, m_cz;
  logic signed [S_W-1:0] sum_x, sum_y, sum_z;
  logic signed [25:0]    px_q, py_q, pz_q;
  logic                  sat_x, sat_y, sat_z;
  logic signed [16:0]    hr, fr;

  function automatic logic signed [15:0] nrm(input logic signed [XU_W-1:0] u);
    logic signed [XU_W:0]    t;
    logic signed [XU_W-16:0] q;
    t = (XU_W+1)'(u) + NRM_HALF;
    q = $signed(t[XU_W:16]);
    if (q > NRM_HI) begin
      return NRM_HI;
    end else if (q < NRM_LO) begin
      return NRM_LO;
    end
    return q[15:0];
  endfunction

  function automatic logic signed [22:0] pos_clip(input logic signed [25:0] p);
    if (p > POS_HI) begin
      return POS_HI;
    end else if (p < POS_LO) begin
      return POS_LO;
    end
    return p[22:0];
  endfunction

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // products, q.30 results floored
  assign m_casc = trig_a.cos_v * trig_c.sin_v;
  assign m_cacc = trig_a.cos_v * trig_c.cos_v;
  assign m_sak  = trig_a.sin_v * $signed({1'b0, coef.ks});
  assign m_sakn = trig_a.sin_v * $signed({1'b0, coef.kn});

  always_ff @(posedge clk) begin
    if (en1) begin
      casc1 <= $signed(m_casc[61:30]);
      cacc1 <= $signed(m_cacc[61:30]);
      sak1  <= $signed(m_sak[61:30]);
      sakn1 <= $signed(m_sakn[61:30]);
      sc1   <= trig_c.sin_v;
      cc1   <= trig_c.cos_v;
      wh1   <= wh;
    end
  end

  assign m_sakc = sak1 * cc1;
  assign m_saks = sak1 * sc1;

  always_ff @(posedge clk) begin
    if (en2) begin
      ux2 <= XU_W'(casc1) + XU_W'($signed(m_sakc[61:30]));
      uz2 <= XU_W'(cacc1) - XU_W'($signed(m_saks[61:30]));
      uy2 <= -XU_W'(sakn1);
      sc2 <= sc1;
      cc2 <= cc1;
      wh2 <= wh1;
    end
  end

  assign hr   = $signed({1'b0, center_radius});
  assign fr   = $signed({1'b0, tube_radius});
  assign m_rx = fr * ux2;
  assign m_ry = fr * uy2;
  assign m_rz = fr * uz2;
  assign m_cx = hr * sc2;
  assign m_cz = hr * cc2;
  assign m_cy = S_W'(wh2) <<< 14;

  always_ff @(posedge clk) begin
    if (en3) begin
      rx3 <= m_rx;
      ry3 <= m_ry;
      rz3 <= m_rz;
      cx3 <= m_cx + ROUND_HALF;
      cy3 <= m_cy + ROUND_HALF;
      cz3 <= m_cz + ROUND_HALF;
      nx3 <= nrm(ux2);
      ny3 <= nrm(uy2);
      nz3 <= nrm(uz2);
    end
  end

  assign sum_x = cx3 + rx3;
  assign sum_y = cy3 + ry3;
  assign sum_z = cz3 + rz3;
  assign px_q  = $signed(sum_x[S_W-1:26]);
  assign py_q  = $signed(sum_y[S_W-1:26]);
  assign pz_q  = $signed(sum_z[S_W-1:26]);
  assign sat_x = (px_q > POS_HI) || (px_q < POS_LO);
  assign sat_y = (py_q > POS_HI) || (py_q < POS_LO);
  assign sat_z = (pz_q > POS_HI) || (pz_q < POS_LO);

  always_ff @(posedge clk) begin
    if (en4) begin
      position_x <= pos_clip(px_q);
      position_y <= pos_clip(py_q);
      position_z <= pos_clip(pz_q);
      normal_x   <= nx3;
      normal_y   <= ny3;
      normal_z   <= nz3;
      saturated  <= sat_x || sat_y || sat_z;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_helix_tube_vertex.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_helix_tube_vertex
// self-checking bench: apb register phases, stalled (u,v) stream, vertex checks
// ----------------------------------------------------------------------------
//
// every accepted (u,v) is run through a bit-exact integer model of the vertex
// math (cordic sine/cosine, slope factors, rounding and saturation) and the
// expected vertex is queued. results are compared in order, field by field.
// the sender works in bursts with random gaps and the receiver stalls on its
// own pattern. registers only change while the pipe is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_helix_tube_vertex;
  import htv_pkg::*;

  localparam int STAGES = 16;
  localparam int DRAIN_CYCLES = STAGES + 20;

  typedef struct {
    logic [16:0] around;
    logic [16:0] along;
  } uv_t;

  typedef struct {
    logic signed [22:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic               sat;
  } vertex_t;

  // rotation angles, 2^-32 turn
  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [16:0] around_fraction, along_fraction;
  logic out_valid, out_ready;
  logic signed [22:0] position_x, position_y, position_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic saturated;

  helix_tube_vertex #(.CORDIC_STAGES(STAGES)) u_dut (.*);

  // shadow copy of the registers
  longint unsigned cfg_radius, cfg_height, cfg_fiber, cfg_loops;

  uv_t     uv_pending[$];
  vertex_t vertex_expected[$];
  int      errors = 0;
  int      vertices_checked = 0;
  int      saturated_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // vertex model
  // ---------------------------------------------------------------------------

  // cordic rotation; top two phase bits select the quadrant
  function automatic void cordic_sincos(input logic [31:0] phase,
                                        output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032875;
    y = 0;
    z = longint'(phase[29:0]);
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i];
      end
    end
    case (quad_t'(phase[31:30]))
      QUAD_0: begin s = y;  c = x;  end
      QUAD_1: begin s = x;  c = -y; end
      QUAD_2: begin s = -y; c = -x; end
      default: begin s = -x; c = y; end
    endcase
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round q.38 to q10.12 and saturate
  function automatic longint round_position(input longint sum, inout logic sat);
    longint p;
    p = (sum + (64'sd1 <<< 25)) >>> 26;
    if (p > 4194303) begin sat = 1'b1; return 4194303; end
    if (p < -4194304) begin sat = 1'b1; return -4194304; end
    return p;
  endfunction

  function automatic vertex_t tube_vertex(input uv_t item);
    vertex_t v;
    longint w, hl, sc, cc, sa, ca, kn, ks, sak, ux, uy, uz;
    longint unsigned g, b, m;
    logic [31:0] helix_phase, tube_phase;
    logic sat;
    w  = 2 * longint'(item.along) - 65536;
    hl = longint'(cfg_height * cfg_loops);
    helix_phase = 32'(w * hl);
    tube_phase  = {item.around[15:0], 16'h0};
    cordic_sincos(helix_phase, sc, cc);
    cordic_sincos(tube_phase, sa, ca);

    // slope factors; the product fits in 64 bits like the datapath
    g = cfg_radius * cfg_loops * 64'd3373259426;
    b = 64'd1 << 45;
    while (g >= (64'd1 << 31) || b >= (64'd1 << 31)) begin
      g >>= 1;
      b >>= 1;
    end
    m = floor_sqrt(g * g + b * b);
    if (m == 0) m = 1;
    kn = clip(longint'((g << 30) / m), 0, 64'sd1 << 30);
    ks = clip(longint'((b << 30) / m), 0, 64'sd1 << 30);

    sak = (sa * ks) >>> 30;
    ux = ((ca * sc) >>> 30) + ((sak * cc) >>> 30);
    uy = -((sa * kn) >>> 30);
    uz = ((ca * cc) >>> 30) - ((sak * sc) >>> 30);

    sat = 1'b0;
    v.px = 23'(round_position(longint'(cfg_radius) * sc + longint'(cfg_fiber) * ux, sat));
    v.py = 23'(round_position((w * longint'(cfg_height)) * 16384
                              + longint'(cfg_fiber) * uy, sat));
    v.pz = 23'(round_position(longint'(cfg_radius) * cc + longint'(cfg_fiber) * uz, sat));
    v.nx = 16'(clip((ux + 32768) >>> 16, -16384, 16384));
    v.ny = 16'(clip((uy + 32768) >>> 16, -16384, 16384));
    v.nz = 16'(clip((uz + 32768) >>> 16, -16384, 16384));
    v.sat = sat;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    uv_t item;
    logic held;
    if (rst) begin
      in_valid <= 1'b0;
      around_fraction <= '0;
      along_fraction <= '0;
    end else begin
      held = in_valid;
      if (in_valid && in_ready) begin
        item.around = around_fraction;
        item.along  = along_fraction;
        vertex_expected.push_back(tube_vertex(item));
        held = 1'b0;
      end
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (uv_pending.size() > 0) begin
          item = uv_pending.pop_front();
          around_fraction <= item.around;
          along_fraction  <= item.along;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // next burst; a quarter of the time run back to back for a while
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int run_left = 0;

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (vertex_expected.size() == 0) begin
          errors++;
          $display("%0t unexpected vertex transfer, nothing expected", $time);
        end else begin
          want = vertex_expected.pop_front();
          check_field("position_x", want.px, position_x);
          check_field("position_y", want.py, position_y);
          check_field("position_z", want.pz, position_z);
          check_field("normal_x", want.nx, normal_x);
          check_field("normal_y", want.ny, normal_y);
          check_field("normal_z", want.nz, normal_z);
          check_field("saturated", want.sat, saturated);
          vertices_checked++;
          if (saturated) saturated_seen++;
        end
      end
      // ready runs alternate with stalls; a third of the time the stall is skipped
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ready <= 1'b1;
      end else begin
        run_left = $urandom_range(0, 30);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        out_ready <= (stall_left == 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and phases
  // ---------------------------------------------------------------------------

  // apb write: setup then access, model register updated at the write edge
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: cfg_radius = data[15:0];
      REG_HEIGHT: cfg_height = data[15:0];
      REG_FIBER:  cfg_fiber  = data[15:0];
      default:    cfg_loops  = data[15:0];
    endcase
  endtask

  // upper data bits are random, only the low 16 land in the register
  task automatic load_shape(input logic [15:0] r, input logic [15:0] h,
                            input logic [15:0] f, input logic [15:0] l);
    reg_write(REG_RADIUS, {16'($urandom), r});
    reg_write(REG_HEIGHT, {16'($urandom), h});
    reg_write(REG_FIBER,  {16'($urandom), f});
    reg_write(REG_LOOPS,  {16'($urandom), l});
  endtask

  function automatic logic [16:0] rand_fraction();
    case ($urandom_range(0, 9))
      0: return 17'($urandom);                          // above 1.0 too
      1: return ($urandom_range(0, 1)) ? 17'd0 : 17'd65536;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic queue_random(input int count);
    uv_t item;
    repeat (count) begin
      item.around = rand_fraction();
      item.along  = rand_fraction();
      uv_pending.push_back(item);
    end
  endtask

  // sender holds off until every vertex is back, then the pipe settles
  task automatic drain();
    while (uv_pending.size() > 0 || in_valid || vertex_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    uv_t item;
    logic [16:0] corner [7];
    corner = '{17'd0, 17'd1, 17'd16384, 17'd32768, 17'd49152, 17'd65536, 17'h1FFFF};
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; around_fraction = '0; along_fraction = '0; out_ready = 1'b0;
    cfg_radius = 256; cfg_height = 256; cfg_fiber = 64; cfg_loops = 256;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset shape: corners of u and v, including wrap of u and v past 1.0
    for (int i = 0; i < 7; i += 2)
      for (int j = 0; j < 7; j++) begin
        item.around = corner[j];
        item.along  = corner[(i + j) % 7];
        uv_pending.push_back(item);
      end
    queue_random(250);
    drain();

    // smallest shape
    load_shape(16'd1, 16'd0, 16'd1, 16'd1);
    queue_random(250);
    drain();

    // largest shape
    load_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(250);
    drain();

    // zero radius, then zero loops: tube ring lies in the x-z plane
    load_shape(16'd0, 16'd512, 16'd128, 16'd300);
    queue_random(150);
    drain();
    load_shape(16'd700, 16'd300, 16'd200, 16'd0);
    queue_random(150);
    drain();

    // assorted shapes
    repeat (4) begin
      load_shape(16'($urandom_range(1, 4096)), 16'($urandom),
                 16'($urandom_range(1, 4096)), 16'($urandom_range(1, 2048)));
      queue_random(200);
      drain();
    end

    $display("covered %0d vertices over 9 register settings, %0d with clipped position",
             vertices_checked, saturated_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d vertices outstanding", vertex_expected.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/htv_pkg.sv
rtl/htv_slope.sv
rtl/htv_cordic.sv
rtl/htv_surface.sv
rtl/helix_tube_vertex.sv
test/tb_helix_tube_vertex.sv
